### rtl/tcce_pkg.sv
package tcce_pkg;

   // Character codes with a special meaning.
   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_SPACE = 8'd32;

   localparam logic [23:0] COLOR_BLACK = 24'h000000;

   // A tab advances by four cells, done as a shift by two.
   localparam int TAB_SHIFT = 2;

   // Result action codes.
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_GLYPH = 2'd1;
   localparam logic [1:0] ACT_FILL  = 2'd2;

   // Request opcodes.
   localparam logic OP_CHAR  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_W = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_H = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_W   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_H   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BG       = 3'd4;

   // Field widths.
   localparam int SCREEN_W  = 16;
   localparam int CELL_W    = 10;
   localparam int COLOR_W   = 24;
   localparam int OUT_XY_W  = 16;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 120;

   // Reset values of the configuration registers.
   localparam logic [SCREEN_W-1:0] SCREEN_W_RST = 16'd1024;
   localparam logic [SCREEN_W-1:0] SCREEN_H_RST = 16'd768;
   localparam logic [CELL_W-1:0]   CELL_W_RST   = 10'd8;
   localparam logic [CELL_W-1:0]   CELL_H_RST   = 10'd16;
   localparam logic [COLOR_W-1:0]  BG_RST       = 24'd0;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic div_start;
      logic div_step;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_align;
      logic div_done;
      logic out_free;
   } ctrl_status_type;

endpackage

### rtl/text_console_cursor_engine.sv
// Text console cursor engine: takes one request at a time (a character or a
// clear command) and returns one draw result per request, carrying the glyph
// or fill to draw and the pixel cursor after the request. An accepted request
// is registered, evaluated, and its result loaded into the output register in
// the commit state once that register is free; only then is the next request
// accepted. A backspace at the start of a line first runs the bit-serial
// remainder unit that aligns the cursor to the last cell of the line above.
// The next request is accepted while a result still waits in the output
// register; its own result then waits until the output register is taken.
// Configuration writes are always ready and should only be issued while no
// request is in flight.
module text_console_cursor_engine
   import tcce_pkg::*;
#(
   parameter int COORD_BITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   // Configuration write channel.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // char_code[7:0], fg_color[31:8]
   input  logic                  req_tuser,  // op
   input  logic                  req_tlast,  // last_char
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // glyph[7:0], draw_fg[31:8], draw_bg[55:32], draw_x[71:56], draw_y[87:72],
   // cursor_x[103:88], cursor_y[119:104]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,  // action
   output logic                  rsp_tlast   // write_done
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   tcce_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcce_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/tcce_controller.sv
module tcce_controller
   import tcce_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EVAL   = 2'd1;
   localparam logic [1:0] ST_ALIGN  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.need_align) begin
               cmd.div_start = 1'b1;
               state_in      = ST_ALIGN;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_ALIGN: begin
            if (status.div_done) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/tcce_datapath.sv
module tcce_datapath
   import tcce_pkg::*;
#(
   parameter int COORD_BITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  ctrl_cmd_type          cmd,
   output ctrl_status_type       status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int SUM_W = SCREEN_W + 1;
   localparam int CNT_W = $clog2(COORD_BITS + 1);

   // Configuration registers.
   logic [SCREEN_W-1:0] screen_w_ff, screen_w_in;
   logic [SCREEN_W-1:0] screen_h_ff, screen_h_in;
   logic [CELL_W-1:0]   cell_w_ff, cell_w_in;
   logic [CELL_W-1:0]   cell_h_ff, cell_h_in;
   logic [COLOR_W-1:0]  bg_ff, bg_in;

   // Captured request.
   logic               op_ff, op_in;
   logic [7:0]         ch_ff, ch_in;
   logic [COLOR_W-1:0] fg_ff, fg_in;
   logic               last_ff, last_in;

   // Cursor and halt state.
   logic [COORD_BITS-1:0] x_ff, x_in;
   logic [COORD_BITS-1:0] y_ff, y_in;
   logic                  halt_ff, halt_in;

   // Alignment remainder unit.
   logic [COORD_BITS-1:0] nx_ff, nx_in;
   logic [COORD_BITS-1:0] src_ff, src_in;
   logic [CELL_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_act_ff, rsp_act_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Step evaluation signals.
   logic                  active;
   logic                  wrap_hit;
   logic                  off_bottom;
   logic [COORD_BITS-1:0] wx, wy;
   logic [COORD_BITS-1:0] align_x;
   logic [COORD_BITS-1:0] new_x, new_y;
   logic                  new_halt;
   logic [1:0]            act;
   logic [7:0]            glyph;
   logic [COLOR_W-1:0]    dfg, dbg;
   logic [COORD_BITS-1:0] dx, dy;
   logic [CELL_W:0]       trial;
   logic                  fits;

   // Configuration writes; indexes past the list are dropped.
   always_comb begin
      screen_w_in = screen_w_ff;
      screen_h_in = screen_h_ff;
      cell_w_in   = cell_w_ff;
      cell_h_in   = cell_h_ff;
      bg_in       = bg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SCREEN_W: screen_w_in = csr_data[SCREEN_W-1:0];
            CSR_SCREEN_H: screen_h_in = csr_data[SCREEN_W-1:0];
            CSR_CELL_W:   cell_w_in   = csr_data[CELL_W-1:0];
            CSR_CELL_H:   cell_h_in   = csr_data[CELL_W-1:0];
            CSR_BG:       bg_in       = csr_data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // Request capture.
   always_comb begin
      op_in   = op_ff;
      ch_in   = ch_ff;
      fg_in   = fg_ff;
      last_in = last_ff;
      if (cmd.capture) begin
         op_in   = req_tuser;
         ch_in   = req_tdata[7:0];
         fg_in   = req_tdata[31:8];
         last_in = req_tlast;
      end
   end

   // Right-edge wrap first, then the bottom-edge test on the wrapped line.
   assign active   = (op_ff == OP_CHAR) && !halt_ff && (ch_ff != CH_ESC);
   assign wrap_hit = (SUM_W'(x_ff) + SUM_W'(cell_w_ff)) > SUM_W'(screen_w_ff);
   assign wx       = wrap_hit ? '0 : x_ff;
   assign wy       = wrap_hit ? (y_ff + COORD_BITS'(cell_h_ff)) : y_ff;
   assign off_bottom = (SUM_W'(wy) + SUM_W'(cell_h_ff)) > SUM_W'(screen_h_ff);

   // Backspace at line start needs the aligned last cell of the line above.
   assign status.need_align = active && !off_bottom && (ch_ff == CH_BS) &&
                              (wx == '0) && (wy != '0);
   assign align_x = (cell_w_ff == '0) ? nx_ff : (nx_ff - COORD_BITS'(rem_ff));

   // Item result and next cursor state.
   always_comb begin
      new_x    = x_ff;
      new_y    = y_ff;
      new_halt = halt_ff;
      act      = ACT_NONE;
      glyph    = '0;
      dfg      = '0;
      dbg      = '0;
      dx       = '0;
      dy       = '0;
      if (op_ff == OP_CLEAR) begin
         act      = ACT_FILL;
         dbg      = bg_ff;
         new_x    = '0;
         new_y    = '0;
         new_halt = 1'b0;
      end else if (active) begin
         new_x = wx;
         new_y = wy;
         if (off_bottom) begin
            new_halt = 1'b1;
         end else if (ch_ff == CH_NL) begin
            new_x = '0;
            new_y = wy + COORD_BITS'(cell_h_ff);
         end else if (ch_ff == CH_TAB) begin
            new_x = wx + (COORD_BITS'(cell_w_ff) << TAB_SHIFT);
         end else if (ch_ff == CH_BS) begin
            if (wx != '0) begin
               new_x = wx - COORD_BITS'(cell_w_ff);
            end else if (wy != '0) begin
               new_y = wy - COORD_BITS'(cell_h_ff);
               new_x = align_x;
            end
            act   = ACT_GLYPH;
            glyph = CH_SPACE;
            dfg   = COLOR_BLACK;
            dbg   = bg_ff;
            dx    = new_x;
            dy    = new_y;
         end else begin
            act   = ACT_GLYPH;
            glyph = ch_ff;
            dfg   = fg_ff;
            dbg   = bg_ff;
            dx    = wx;
            dy    = wy;
            new_x = wx + COORD_BITS'(cell_w_ff);
         end
      end
      // The end of a write request always releases the halt.
      if (op_ff == OP_CHAR && last_ff) begin
         new_halt = 1'b0;
      end
   end

   // Restoring remainder by the cell width, one dividend bit per cycle.
   assign trial = {rem_ff, src_ff[COORD_BITS-1]};
   assign fits  = trial >= {1'b0, cell_w_ff};

   always_comb begin
      nx_in  = nx_ff;
      src_in = src_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.div_start) begin
         nx_in  = screen_w_ff[COORD_BITS-1:0] - COORD_BITS'(cell_w_ff);
         src_in = screen_w_ff[COORD_BITS-1:0] - COORD_BITS'(cell_w_ff);
         rem_in = '0;
         cnt_in = CNT_W'(COORD_BITS);
      end else if (cmd.div_step) begin
         src_in = {src_ff[COORD_BITS-2:0], 1'b0};
         rem_in = fits ? CELL_W'(trial - {1'b0, cell_w_ff}) : trial[CELL_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   assign status.div_done = (cnt_ff == '0);

   // Cursor update and result register load.
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      x_in         = x_ff;
      y_in         = y_ff;
      halt_in      = halt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.commit) begin
         x_in         = new_x;
         y_in         = new_y;
         halt_in      = new_halt;
         rsp_valid_in = 1'b1;
         rsp_act_in   = act;
         rsp_last_in  = last_ff;
         rsp_data_in  = {OUT_XY_W'(new_y), OUT_XY_W'(new_x),
                         OUT_XY_W'(dy), OUT_XY_W'(dx), dbg, dfg, glyph};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_w_ff  <= SCREEN_W_RST;
         screen_h_ff  <= SCREEN_H_RST;
         cell_w_ff    <= CELL_W_RST;
         cell_h_ff    <= CELL_H_RST;
         bg_ff        <= BG_RST;
         x_ff         <= '0;
         y_ff         <= '0;
         halt_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         screen_w_ff  <= screen_w_in;
         screen_h_ff  <= screen_h_in;
         cell_w_ff    <= cell_w_in;
         cell_h_ff    <= cell_h_in;
         bg_ff        <= bg_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         halt_ff      <= halt_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      fg_ff       <= fg_in;
      last_ff     <= last_in;
      nx_ff       <= nx_in;
      src_ff      <= src_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_act_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
